FILE: rtl/atlp_pkg.sv
// Shared types, constants and command/status structs for the text layout parser.
package atlp_pkg;

  localparam int SEGMENT_DEPTH = 32;
  localparam int GLYPH_WIDTH   = 12;
  localparam int PANEL_WIDTH   = 212;

  localparam int SEG_AW    = $clog2(SEGMENT_DEPTH);
  localparam int FILL_W    = 6;
  localparam int COORD_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_BLACK  = 3'd0,
    CFG_CODE_RED    = 3'd1,
    CFG_CODE_RIGHT  = 3'd2,
    CFG_CODE_CENTER = 3'd3,
    CFG_CODE_END    = 3'd4,
    CFG_LEFT_MARGIN = 3'd5,
    CFG_TOP_MARGIN  = 3'd6,
    CFG_LINE_PITCH  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    EV_WRITE   = 3'd0,
    EV_CURSOR  = 3'd1,
    EV_COLOR   = 3'd2,
    EV_REFRESH = 3'd3,
    EV_DROP    = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_LEFT   = 2'd1,
    MODE_RIGHT  = 2'd2,
    MODE_CENTER = 2'd3
  } parse_mode_t;

  typedef enum logic [1:0] {
    CUR_START = 2'd0,
    CUR_LINE  = 2'd1,
    CUR_SEG   = 2'd2
  } cur_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_COLOR,
    ST_START_CURSOR,
    ST_BODY,
    ST_NL_CURSOR,
    ST_SEG_CURSOR,
    ST_REPLAY
  } ctrl_state_t;

  typedef struct packed {
    logic        capture;
    logic        emit;
    event_kind_t kind;
    logic        red;
    logic        last;
    logic        from_replay;
    cur_sel_t    cur_sel;
    logic        set_mode;
    parse_mode_t mode_val;
    logic        clear_seg;
    logic        clear_line;
    logic        inc_line;
    logic        store;
    logic        store_color;
    logic        rd_first;
    logic        rd_next;
  } dp_cmd_t;

  typedef struct packed {
    parse_mode_t mode;
    logic        is_zero;
    logic        is_nl;
    logic        is_black;
    logic        is_red;
    logic        is_right;
    logic        is_center;
    logic        is_end;
    logic        seg_full;
    logic        seg_empty;
    logic        rep_last;
    logic        rep_black;
    logic        rep_red;
    logic        out_free;
  } dp_status_t;

endpackage

FILE: rtl/atlp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module atlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/atlp_datapath.sv
// Datapath: config registers, parse state, segment store, cursor maths, output register.
module atlp_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [atlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic [7:0]                     char_code,
  input  atlp_pkg::dp_cmd_t              cmd,
  output atlp_pkg::dp_status_t           status,
  output logic                           event_valid,
  input  logic                           event_stall,
  output logic [2:0]                     event_kind,
  output logic [7:0]                     glyph,
  output logic signed [15:0]             cursor_x,
  output logic signed [15:0]             cursor_y,
  output logic                           color_red,
  output logic                           last_of_run
);

  localparam int FW = atlp_pkg::FILL_W;
  localparam int CW = atlp_pkg::COORD_W;
  localparam int AW = atlp_pkg::SEG_AW;

  logic [7:0] code_black, code_red, code_right, code_center, code_end;
  logic [7:0] left_margin, top_margin, line_pitch;

  atlp_pkg::parse_mode_t mode;
  logic [7:0]    line_index;
  logic [FW-1:0] fill;
  logic [FW-1:0] color_count;
  logic [FW-1:0] idx;
  logic [7:0]    cur_byte;
  logic [7:0]    rdata;
  logic [AW-1:0] raddr;
  logic          out_free;

  logic [FW-1:0]        n_chars;
  logic [CW-1:0]        line_y;
  logic signed [CW-1:0] glyph_span;
  logic signed [CW-1:0] right_x;
  logic signed [CW-1:0] center_v;
  logic signed [CW-1:0] center_x;
  logic signed [CW-1:0] sel_x;
  logic signed [CW-1:0] sel_y;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      code_black  <= 8'd1;
      code_red    <= 8'd2;
      code_right  <= 8'd3;
      code_center <= 8'd4;
      code_end    <= 8'd5;
      left_margin <= 8'd0;
      top_margin  <= 8'd0;
      line_pitch  <= 8'd16;
    end else if (cfg_valid) begin
      unique case (atlp_pkg::cfg_reg_t'(cfg_index))
        atlp_pkg::CFG_CODE_BLACK:  code_black  <= cfg_data;
        atlp_pkg::CFG_CODE_RED:    code_red    <= cfg_data;
        atlp_pkg::CFG_CODE_RIGHT:  code_right  <= cfg_data;
        atlp_pkg::CFG_CODE_CENTER: code_center <= cfg_data;
        atlp_pkg::CFG_CODE_END:    code_end    <= cfg_data;
        atlp_pkg::CFG_LEFT_MARGIN: left_margin <= cfg_data;
        atlp_pkg::CFG_TOP_MARGIN:  top_margin  <= cfg_data;
        atlp_pkg::CFG_LINE_PITCH:  line_pitch  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_byte <= char_code;
    end
    if (cmd.rd_first) begin
      idx <= '0;
    end else if (cmd.emit && cmd.from_replay) begin
      idx <= idx + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= atlp_pkg::MODE_START;
      line_index  <= '0;
      fill        <= '0;
      color_count <= '0;
    end else begin
      if (cmd.set_mode) begin
        mode <= cmd.mode_val;
      end
      if (cmd.clear_line) begin
        line_index <= '0;
      end else if (cmd.inc_line) begin
        line_index <= line_index + 8'd1;
      end
      if (cmd.clear_seg) begin
        fill        <= '0;
        color_count <= '0;
      end else if (cmd.store) begin
        fill <= fill + FW'(1);
        if (cmd.store_color) begin
          color_count <= color_count + FW'(1);
        end
      end
    end
  end

  assign raddr = cmd.rd_next ? AW'(idx + FW'(1)) : '0;

  atlp_ram #(
    .WIDTH (8),
    .DEPTH (atlp_pkg::SEGMENT_DEPTH)
  ) u_seg_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (fill[AW-1:0]),
    .wdata (cur_byte),
    .re    (cmd.rd_first | cmd.rd_next),
    .raddr (raddr),
    .rdata (rdata)
  );

  // cursor arithmetic, all exact within 16 bits for the parameter ranges
  assign n_chars    = fill - color_count;
  assign line_y     = CW'({8'd0, top_margin}) + ({8'd0, line_index} * {8'd0, line_pitch});
  assign glyph_span = CW'(atlp_pkg::GLYPH_WIDTH) * CW'(n_chars);
  assign right_x    = CW'(atlp_pkg::PANEL_WIDTH) - CW'({8'd0, left_margin}) - glyph_span;
  assign center_v   = CW'(atlp_pkg::PANEL_WIDTH) - glyph_span;
  // halve rounding toward zero
  assign center_x   = (center_v + $signed(CW'(center_v[CW-1]))) >>> 1;

  always_comb begin
    unique case (cmd.cur_sel)
      atlp_pkg::CUR_START: begin
        sel_x = CW'({8'd0, left_margin});
        sel_y = CW'({8'd0, top_margin});
      end
      atlp_pkg::CUR_LINE: begin
        sel_x = CW'({8'd0, left_margin});
        sel_y = line_y;
      end
      atlp_pkg::CUR_SEG: begin
        sel_x = (mode == atlp_pkg::MODE_RIGHT) ? right_x : center_x;
        sel_y = line_y;
      end
      default: begin
        sel_x = '0;
        sel_y = '0;
      end
    endcase
  end

  assign out_free = !event_valid || !event_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (cmd.emit) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      event_kind  <= cmd.kind;
      glyph       <= (cmd.kind == atlp_pkg::EV_WRITE) ?
                     (cmd.from_replay ? rdata : cur_byte) : 8'd0;
      cursor_x    <= (cmd.kind == atlp_pkg::EV_CURSOR) ? sel_x : '0;
      cursor_y    <= (cmd.kind == atlp_pkg::EV_CURSOR) ? sel_y : '0;
      color_red   <= (cmd.kind == atlp_pkg::EV_COLOR) ? cmd.red : 1'b0;
      last_of_run <= cmd.last;
    end
  end

  always_comb begin
    status           = '0;
    status.mode      = mode;
    status.is_zero   = (cur_byte == 8'd0);
    status.is_nl     = (cur_byte == atlp_pkg::NEWLINE_BYTE);
    status.is_black  = (cur_byte == code_black);
    status.is_red    = (cur_byte == code_red);
    status.is_right  = (cur_byte == code_right);
    status.is_center = (cur_byte == code_center);
    status.is_end    = (cur_byte == code_end);
    status.seg_full  = (fill >= FW'(atlp_pkg::SEGMENT_DEPTH));
    status.seg_empty = (fill == '0);
    status.rep_last  = ((idx + FW'(1)) == fill);
    status.rep_black = (rdata == code_black);
    status.rep_red   = (rdata == code_red);
    status.out_free  = out_free;
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result loaded over an item not yet taken");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(atlp_pkg::SEGMENT_DEPTH))
    else $error("segment fill beyond store depth");

  a_color_bound: assert property (@(posedge clk) disable iff (rst)
    color_count <= fill)
    else $error("colour count exceeds segment fill");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> !status.seg_full && (mode == atlp_pkg::MODE_RIGHT ||
                                       mode == atlp_pkg::MODE_CENTER))
    else $error("store outside an open segment or into a full store");
`endif

endmodule

FILE: rtl/atlp_ctrl.sv
// Controller state machine sequencing the results of each input item.
module atlp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  atlp_pkg::dp_status_t status,
  output atlp_pkg::dp_cmd_t    cmd
);

  atlp_pkg::ctrl_state_t state, state_next;

  logic go;
  logic seg_close;
  logic open_only;

  assign go        = status.out_free;
  // in a segment only code_end closes, and only when no earlier code matched
  assign seg_close = !status.is_nl && !status.is_black && !status.is_red && status.is_end;
  // after the start results, a segment-open byte adds nothing more
  assign open_only = !status.is_zero && !status.is_nl && !status.is_black &&
                     !status.is_red && (status.is_right || status.is_center);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atlp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      atlp_pkg::ST_IDLE: begin
        if (char_valid) begin
          state_next = (status.mode == atlp_pkg::MODE_START) ?
                       atlp_pkg::ST_START_COLOR : atlp_pkg::ST_BODY;
        end
      end
      atlp_pkg::ST_START_COLOR: begin
        if (go) state_next = atlp_pkg::ST_START_CURSOR;
      end
      atlp_pkg::ST_START_CURSOR: begin
        if (go) state_next = atlp_pkg::ST_BODY;
      end
      atlp_pkg::ST_BODY: begin
        if (status.is_zero) begin
          if (go) state_next = atlp_pkg::ST_IDLE;
        end else if (status.mode == atlp_pkg::MODE_LEFT) begin
          if (status.is_nl) begin
            state_next = atlp_pkg::ST_NL_CURSOR;
          end else if (!status.is_black && !status.is_red &&
                       (status.is_right || status.is_center)) begin
            state_next = atlp_pkg::ST_IDLE;
          end else if (go) begin
            state_next = atlp_pkg::ST_IDLE;
          end
        end else if (seg_close) begin
          state_next = atlp_pkg::ST_SEG_CURSOR;
        end else if (!status.seg_full || go) begin
          state_next = atlp_pkg::ST_IDLE;
        end
      end
      atlp_pkg::ST_NL_CURSOR: begin
        if (go) state_next = atlp_pkg::ST_IDLE;
      end
      atlp_pkg::ST_SEG_CURSOR: begin
        if (go) begin
          state_next = status.seg_empty ? atlp_pkg::ST_IDLE : atlp_pkg::ST_REPLAY;
        end
      end
      atlp_pkg::ST_REPLAY: begin
        if (go && status.rep_last) state_next = atlp_pkg::ST_IDLE;
      end
      default: state_next = atlp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    char_stall = (state != atlp_pkg::ST_IDLE);
    unique case (state)
      atlp_pkg::ST_IDLE: begin
        cmd.capture = char_valid;
      end
      atlp_pkg::ST_START_COLOR: begin
        if (go) begin
          cmd.emit       = 1'b1;
          cmd.kind       = atlp_pkg::EV_COLOR;
          cmd.red        = 1'b1;
          cmd.clear_line = 1'b1;
          cmd.clear_seg  = 1'b1;
          cmd.set_mode   = 1'b1;
          cmd.mode_val   = atlp_pkg::MODE_LEFT;
        end
      end
      atlp_pkg::ST_START_CURSOR: begin
        if (go) begin
          cmd.emit    = 1'b1;
          cmd.kind    = atlp_pkg::EV_CURSOR;
          cmd.cur_sel = atlp_pkg::CUR_START;
          cmd.last    = open_only;
        end
      end
      atlp_pkg::ST_BODY: begin
        if (status.is_zero) begin
          if (go) begin
            cmd.emit      = 1'b1;
            cmd.kind      = atlp_pkg::EV_REFRESH;
            cmd.last      = 1'b1;
            cmd.clear_seg = 1'b1;
            cmd.set_mode  = 1'b1;
            cmd.mode_val  = atlp_pkg::MODE_START;
          end
        end else if (status.mode == atlp_pkg::MODE_LEFT) begin
          if (status.is_nl) begin
            cmd.inc_line = 1'b1;
          end else if (status.is_black || status.is_red) begin
            if (go) begin
              cmd.emit = 1'b1;
              cmd.kind = atlp_pkg::EV_COLOR;
              cmd.red  = !status.is_black;
              cmd.last = 1'b1;
            end
          end else if (status.is_right || status.is_center) begin
            cmd.set_mode  = 1'b1;
            cmd.mode_val  = status.is_right ? atlp_pkg::MODE_RIGHT : atlp_pkg::MODE_CENTER;
            cmd.clear_seg = 1'b1;
          end else if (go) begin
            cmd.emit = 1'b1;
            cmd.kind = atlp_pkg::EV_WRITE;
            cmd.last = 1'b1;
          end
        end else if (!seg_close) begin
          if (!status.seg_full) begin
            cmd.store       = 1'b1;
            cmd.store_color = !status.is_nl && (status.is_black || status.is_red);
          end else if (go) begin
            cmd.emit = 1'b1;
            cmd.kind = atlp_pkg::EV_DROP;
            cmd.last = 1'b1;
          end
        end
      end
      atlp_pkg::ST_NL_CURSOR: begin
        if (go) begin
          cmd.emit    = 1'b1;
          cmd.kind    = atlp_pkg::EV_CURSOR;
          cmd.cur_sel = atlp_pkg::CUR_LINE;
          cmd.last    = 1'b1;
        end
      end
      atlp_pkg::ST_SEG_CURSOR: begin
        if (go) begin
          cmd.emit    = 1'b1;
          cmd.kind    = atlp_pkg::EV_CURSOR;
          cmd.cur_sel = atlp_pkg::CUR_SEG;
          cmd.last    = status.seg_empty;
          if (status.seg_empty) begin
            cmd.clear_seg = 1'b1;
            cmd.set_mode  = 1'b1;
            cmd.mode_val  = atlp_pkg::MODE_LEFT;
          end else begin
            cmd.rd_first = 1'b1;
          end
        end
      end
      atlp_pkg::ST_REPLAY: begin
        if (go) begin
          cmd.emit        = 1'b1;
          cmd.from_replay = 1'b1;
          cmd.kind        = (status.rep_black || status.rep_red) ?
                            atlp_pkg::EV_COLOR : atlp_pkg::EV_WRITE;
          cmd.red         = !status.rep_black && status.rep_red;
          cmd.last        = status.rep_last;
          if (status.rep_last) begin
            cmd.clear_seg = 1'b1;
            cmd.set_mode  = 1'b1;
            cmd.mode_val  = atlp_pkg::MODE_LEFT;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/aligned_text_layout_parser_core.sv
// Top level of the aligned text layout parser: controller, datapath, config port.
//
// One text byte is taken per item whenever the controller is idle; each item then runs to
// completion before the next is accepted. A plain byte is accepted and then gives one result,
// the first byte of a string gives its colour and cursor results first, a newline steps the
// line index and then gives a cursor result, and a byte that is only buffered gives none.
// Closing an aligned segment gives a cursor result, then one result per buffered byte:
// the segment store is a RAM with registered read, and replay fetches the next byte in
// the same cycle the current one is issued. A stall on the result side holds any step that
// issues a result. The segment store needs no clearing after reset. Configuration writes
// are always ready and take effect at once; write them only while no item is in progress.
module aligned_text_layout_parser_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           char_valid,
  output logic                           char_stall,
  input  logic [7:0]                     char_code,
  output logic                           event_valid,
  input  logic                           event_stall,
  output logic [2:0]                     event_kind,
  output logic [7:0]                     glyph,
  output logic signed [15:0]             cursor_x,
  output logic signed [15:0]             cursor_y,
  output logic                           color_red,
  output logic                           last_of_run,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [atlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  atlp_pkg::dp_cmd_t    cmd;
  atlp_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  atlp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .status     (status),
    .cmd        (cmd)
  );

  atlp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .char_code   (char_code),
    .cmd         (cmd),
    .status      (status),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_kind  (event_kind),
    .glyph       (glyph),
    .cursor_x    (cursor_x),
    .cursor_y    (cursor_y),
    .color_red   (color_red),
    .last_of_run (last_of_run)
  );

endmodule

FILE: tb/aligned_text_layout_parser_core_tb.sv
// Self-checking testbench for aligned_text_layout_parser_core: directed rows, then random text.
`timescale 1ns / 1ps

module aligned_text_layout_parser_core_tb;
  import atlp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    event_kind_t kind;
    logic [7:0]  glyph;
    logic [15:0] x;
    logic [15:0] y;
    logic        red;
    logic        last;
  } layout_ev_t;

  typedef struct {
    logic [7:0] code;
    bit         typed;
    layout_ev_t ev;
  } script_row_t;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_HOLD, STALL_PERIODIC} stall_style_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 char_valid = 1'b0;
  logic                 char_stall;
  logic [7:0]           char_code = 8'd0;
  logic                 event_valid;
  logic                 event_stall = 1'b0;
  logic [2:0]           event_kind;
  logic [7:0]           glyph;
  logic signed [15:0]   cursor_x;
  logic signed [15:0]   cursor_y;
  logic                 color_red;
  logic                 last_of_run;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'd0;

  aligned_text_layout_parser_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .event_kind (event_kind),
    .glyph      (glyph),
    .cursor_x   (cursor_x),
    .cursor_y   (cursor_y),
    .color_red  (color_red),
    .last_of_run(last_of_run),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // layout state mirrored by the predictor
  logic [7:0]  reg_val [8];
  parse_mode_t pmode;
  logic [7:0]  line_idx;
  logic [7:0]  seg_mem [SEGMENT_DEPTH];
  int          seg_fill;
  int          color_cnt;

  layout_ev_t  pending_events[$];
  script_row_t script_rows[$];
  logic [7:0]  text_q[$];

  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int drain_at = -1;
  int burst_left = 4;
  bit force_long;

  task automatic note_err(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  function automatic layout_ev_t mk_ev(event_kind_t k, logic [7:0] g, logic [15:0] x,
                                       logic [15:0] y, logic red);
    layout_ev_t e;
    e.kind  = k;
    e.glyph = g;
    e.x     = x;
    e.y     = y;
    e.red   = red;
    e.last  = 1'b0;
    return e;
  endfunction

  function automatic logic [15:0] line_y();
    return 16'(int'(reg_val[CFG_TOP_MARGIN]) + int'(line_idx) * int'(reg_val[CFG_LINE_PITCH]));
  endfunction

  task automatic seg_store(input logic [7:0] c, input bit is_color, ref layout_ev_t q[$]);
    if (seg_fill >= SEGMENT_DEPTH) begin
      q.push_back(mk_ev(EV_DROP, 8'd0, 16'd0, 16'd0, 1'b0));
    end else begin
      seg_mem[seg_fill] = c;
      seg_fill++;
      if (is_color) color_cnt++;
    end
  endtask

  // events caused by one text byte
  task automatic layout_byte(input logic [7:0] c, ref layout_ev_t q[$]);
    int n;
    int xv;
    if (pmode == MODE_START) begin
      line_idx  = 8'd0;
      seg_fill  = 0;
      color_cnt = 0;
      q.push_back(mk_ev(EV_COLOR, 8'd0, 16'd0, 16'd0, 1'b1));
      q.push_back(mk_ev(EV_CURSOR, 8'd0, {8'd0, reg_val[CFG_LEFT_MARGIN]},
                        {8'd0, reg_val[CFG_TOP_MARGIN]}, 1'b0));
      pmode = MODE_LEFT;
    end
    if (c == 8'd0) begin
      seg_fill  = 0;
      color_cnt = 0;
      pmode     = MODE_START;
      q.push_back(mk_ev(EV_REFRESH, 8'd0, 16'd0, 16'd0, 1'b0));
    end else if (pmode == MODE_LEFT) begin
      if (c == NEWLINE_BYTE) begin
        line_idx++;
        q.push_back(mk_ev(EV_CURSOR, 8'd0, {8'd0, reg_val[CFG_LEFT_MARGIN]}, line_y(), 1'b0));
      end else if (c == reg_val[CFG_CODE_BLACK]) begin
        q.push_back(mk_ev(EV_COLOR, 8'd0, 16'd0, 16'd0, 1'b0));
      end else if (c == reg_val[CFG_CODE_RED]) begin
        q.push_back(mk_ev(EV_COLOR, 8'd0, 16'd0, 16'd0, 1'b1));
      end else if (c == reg_val[CFG_CODE_RIGHT] || c == reg_val[CFG_CODE_CENTER]) begin
        pmode     = (c == reg_val[CFG_CODE_RIGHT]) ? MODE_RIGHT : MODE_CENTER;
        seg_fill  = 0;
        color_cnt = 0;
      end else begin
        q.push_back(mk_ev(EV_WRITE, c, 16'd0, 16'd0, 1'b0));
      end
    end else if (c == NEWLINE_BYTE) begin
      seg_store(c, 1'b0, q);
    end else if (c == reg_val[CFG_CODE_BLACK] || c == reg_val[CFG_CODE_RED]) begin
      seg_store(c, 1'b1, q);
    end else if (c == reg_val[CFG_CODE_END]) begin
      n = seg_fill - color_cnt;
      if (pmode == MODE_RIGHT)
        xv = PANEL_WIDTH - int'(reg_val[CFG_LEFT_MARGIN]) - GLYPH_WIDTH * n;
      else
        xv = (PANEL_WIDTH - GLYPH_WIDTH * n) / 2;
      q.push_back(mk_ev(EV_CURSOR, 8'd0, xv[15:0], line_y(), 1'b0));
      for (int i = 0; i < seg_fill; i++) begin
        if (seg_mem[i] == reg_val[CFG_CODE_BLACK])
          q.push_back(mk_ev(EV_COLOR, 8'd0, 16'd0, 16'd0, 1'b0));
        else if (seg_mem[i] == reg_val[CFG_CODE_RED])
          q.push_back(mk_ev(EV_COLOR, 8'd0, 16'd0, 16'd0, 1'b1));
        else
          q.push_back(mk_ev(EV_WRITE, seg_mem[i], 16'd0, 16'd0, 1'b0));
      end
      seg_fill  = 0;
      color_cnt = 0;
      pmode     = MODE_LEFT;
    end else begin
      seg_store(c, 1'b0, q);
    end
    if (q.size() > 0) q[q.size() - 1].last = 1'b1;
  endtask

  // lower valid and wait until every predicted event has come out
  task automatic drain();
    @(negedge clk);
    char_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    // a buffered byte gives no event but keeps the block busy briefly
    repeat (4) @(posedge clk);
  endtask

  task automatic send_char(input logic [7:0] c, output layout_ev_t last_ev, output bit any);
    layout_ev_t run_q[$];
    int gap;
    if (sent == drain_at) drain();
    @(negedge clk);
    char_valid <= 1'b1;
    char_code  <= c;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    layout_byte(c, run_q);
    foreach (run_q[i]) pending_events.push_back(run_q[i]);
    any = (run_q.size() > 0);
    if (any) last_ev = run_q[run_q.size() - 1];
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      @(negedge clk);
      char_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_val[idx] = v;
  endtask

  task automatic set_regs(input logic [7:0] blk, red, rgt, ctr, fin, ml, mt, pitch);
    drain();
    write_reg(CFG_CODE_BLACK, blk);
    write_reg(CFG_CODE_RED, red);
    write_reg(CFG_CODE_RIGHT, rgt);
    write_reg(CFG_CODE_CENTER, ctr);
    write_reg(CFG_CODE_END, fin);
    write_reg(CFG_LEFT_MARGIN, ml);
    write_reg(CFG_TOP_MARGIN, mt);
    write_reg(CFG_LINE_PITCH, pitch);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [7:0] code, input bit typed, input event_kind_t k,
                         input logic [7:0] g, input int x, input int y, input logic red);
    script_row_t r;
    r.code  = code;
    r.typed = typed;
    r.ev    = mk_ev(k, g, x[15:0], y[15:0], red);
    script_rows.push_back(r);
  endtask

  function automatic logic [7:0] seg_content();
    case ($urandom_range(0, 9))
      0:       return NEWLINE_BYTE;
      1:       return reg_val[CFG_CODE_BLACK];
      2:       return reg_val[CFG_CODE_RED];
      3:       return $urandom_range(0, 1) ? reg_val[CFG_CODE_RIGHT] : reg_val[CFG_CODE_CENTER];
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // one string: text, newlines, colours and aligned segments, then the terminator
  task automatic build_string();
    int len;
    text_q.delete();
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(1, 255)));
        4: text_q.push_back(NEWLINE_BYTE);
        5: text_q.push_back($urandom_range(0, 1) ? reg_val[CFG_CODE_BLACK]
                                                  : reg_val[CFG_CODE_RED]);
        6, 7, 8: begin
          text_q.push_back($urandom_range(0, 1) ? reg_val[CFG_CODE_RIGHT]
                                                 : reg_val[CFG_CODE_CENTER]);
          len = (force_long || $urandom_range(0, 5) == 0) ? $urandom_range(30, 36)
                                                          : $urandom_range(0, 8);
          force_long = 1'b0;
          repeat (len) text_q.push_back(seg_content());
          // now and then leave the segment open for the terminator to drop
          if ($urandom_range(0, 7) != 0) text_q.push_back(reg_val[CFG_CODE_END]);
        end
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    text_q.push_back(8'd0);
  endtask

  task automatic run_random(input int target);
    int count;
    layout_ev_t last_ev;
    bit any;
    count      = 0;
    force_long = 1'b1;
    while (count < target) begin
      build_string();
      foreach (text_q[i]) send_char(text_q[i], last_ev, any);
      count += text_q.size();
    end
  endtask

  // receiver stall pattern
  stall_style_t stall_style = STALL_NONE;
  int style_left = 0;
  int hold_left = 0;
  int ring = 0;

  always @(negedge clk) begin
    ring <= ring + 1;
    if (rst) begin
      event_stall <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style <= stall_style_t'($urandom_range(0, 3));
        style_left  <= $urandom_range(20, 80);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        STALL_NONE: event_stall <= 1'b0;
        STALL_COIN: event_stall <= ($urandom_range(0, 1) == 1);
        STALL_HOLD: begin
          if (hold_left == 0) begin
            event_stall <= ~event_stall;
            hold_left   <= $urandom_range(1, 12);
          end else begin
            hold_left <= hold_left - 1;
          end
        end
        default: event_stall <= (ring % 4 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    layout_ev_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (!rst && event_valid && !event_stall) begin
      if (pending_events.size() == 0) begin
        note_err($sformatf("unexpected event kind %0d glyph %0d x %0d y %0d red %0b last %0b",
                           event_kind, glyph, cursor_x, cursor_y, color_red, last_of_run));
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind || glyph !== want.glyph || cursor_x !== want.x ||
            cursor_y !== want.y || color_red !== want.red || last_of_run !== want.last)
          note_err($sformatf({"event mismatch: expected kind %0d glyph %0d x %0d y %0d red %0b",
                              " last %0b, got kind %0d glyph %0d x %0d y %0d red %0b last %0b"},
                             want.kind, want.glyph, $signed(want.x), $signed(want.y), want.red,
                             want.last, event_kind, glyph, cursor_x, cursor_y, color_red,
                             last_of_run));
      end
    end
  end

  initial begin
    layout_ev_t last_ev;
    bit any;
    reg_val[CFG_CODE_BLACK]  = 8'd1;
    reg_val[CFG_CODE_RED]    = 8'd2;
    reg_val[CFG_CODE_RIGHT]  = 8'd3;
    reg_val[CFG_CODE_CENTER] = 8'd4;
    reg_val[CFG_CODE_END]    = 8'd5;
    reg_val[CFG_LEFT_MARGIN] = 8'd0;
    reg_val[CFG_TOP_MARGIN]  = 8'd0;
    reg_val[CFG_LINE_PITCH]  = 8'd16;
    pmode     = MODE_START;
    line_idx  = 8'd0;
    seg_fill  = 0;
    color_cnt = 0;
    foreach (seg_mem[i]) seg_mem[i] = 8'd0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed rows under the reset settings
    add_row(8'd0, 1, EV_REFRESH, 8'd0, 0, 0, 1'b0);          // terminator as first byte
    add_row(8'd65, 1, EV_WRITE, 8'd65, 0, 0, 1'b0);
    add_row(8'd255, 1, EV_WRITE, 8'd255, 0, 0, 1'b0);
    add_row(NEWLINE_BYTE, 1, EV_CURSOR, 8'd0, 0, 16, 1'b0);
    add_row(reg_val[CFG_CODE_BLACK], 1, EV_COLOR, 8'd0, 0, 0, 1'b0);
    add_row(reg_val[CFG_CODE_RED], 1, EV_COLOR, 8'd0, 0, 0, 1'b1);
    add_row(reg_val[CFG_CODE_END], 1, EV_WRITE, reg_val[CFG_CODE_END], 0, 0, 1'b0);
    add_row(reg_val[CFG_CODE_RIGHT], 0, EV_WRITE, 8'd0, 0, 0, 1'b0);
    add_row(8'd66, 0, EV_WRITE, 8'd0, 0, 0, 1'b0);
    add_row(reg_val[CFG_CODE_RED], 0, EV_WRITE, 8'd0, 0, 0, 1'b0);
    add_row(NEWLINE_BYTE, 0, EV_WRITE, 8'd0, 0, 0, 1'b0);    // stored, not a line break
    add_row(reg_val[CFG_CODE_CENTER], 0, EV_WRITE, 8'd0, 0, 0, 1'b0);
    add_row(8'd67, 0, EV_WRITE, 8'd0, 0, 0, 1'b0);
    add_row(reg_val[CFG_CODE_END], 1, EV_WRITE, 8'd67, 0, 0, 1'b0);
    add_row(reg_val[CFG_CODE_CENTER], 0, EV_WRITE, 8'd0, 0, 0, 1'b0);
    add_row(8'd120, 0, EV_WRITE, 8'd0, 0, 0, 1'b0);
    add_row(8'd121, 0, EV_WRITE, 8'd0, 0, 0, 1'b0);
    add_row(reg_val[CFG_CODE_END], 1, EV_WRITE, 8'd121, 0, 0, 1'b0);
    add_row(reg_val[CFG_CODE_RIGHT], 0, EV_WRITE, 8'd0, 0, 0, 1'b0);
    add_row(8'd88, 0, EV_WRITE, 8'd0, 0, 0, 1'b0);
    add_row(8'd0, 1, EV_REFRESH, 8'd0, 0, 0, 1'b0);          // drops the open segment
    add_row(NEWLINE_BYTE, 1, EV_CURSOR, 8'd0, 0, 16, 1'b0);
    add_row(8'd0, 1, EV_REFRESH, 8'd0, 0, 0, 1'b0);

    foreach (script_rows[i]) begin
      send_char(script_rows[i].code, last_ev, any);
      if (script_rows[i].typed &&
          (!any || last_ev.kind !== script_rows[i].ev.kind ||
           last_ev.glyph !== script_rows[i].ev.glyph || last_ev.x !== script_rows[i].ev.x ||
           last_ev.y !== script_rows[i].ev.y || last_ev.red !== script_rows[i].ev.red))
        note_err($sformatf("directed row %0d: predicted final event differs from table", i));
    end

    drain_at = sent + $urandom_range(60, 120);

    set_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_random(22);
    set_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    run_random(22);
    set_regs(8'd251, 8'd252, 8'd253, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255);
    run_random(22);
    // closing code equal to newline: segments only end at the terminator
    set_regs(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
             8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), NEWLINE_BYTE,
             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
    run_random(22);
    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random(22);
    set_regs(8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd0, 8'd0, 8'd16);
    run_random(22);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/atlp_pkg.sv
rtl/atlp_ram.sv
rtl/atlp_datapath.sv
rtl/atlp_ctrl.sv
rtl/aligned_text_layout_parser_core.sv
tb/aligned_text_layout_parser_core_tb.sv
